[src/ecsm_pkg.sv]
// Shared constants for the affine elliptic-curve scalar multiplier.
// No dependencies; used by ecsm_mulmod and ec_affine_scalar_mul_fp_unit.
package ecsm_pkg;

	localparam int FIELD_BITS_DEF  = 32;
	localparam int SCALAR_BITS_DEF = 64;

	// modulus after reset and smallest usable modulus
	localparam logic [63:0] MODULUS_RESET = 64'd4294967291;
	localparam logic [63:0] MODULUS_MIN   = 64'd3;

endpackage

[src/ecsm_mulmod.sv]
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
// Depends on ecsm_pkg for the default field width.
module ecsm_mulmod #(
	parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [FIELD_BITS-1:0] a,
	input  logic [FIELD_BITS-1:0] b,
	input  logic [FIELD_BITS-1:0] m,
	output logic                  done,
	output logic [FIELD_BITS-1:0] p
);

	localparam int CW = $clog2(FIELD_BITS + 1);

	logic [FIELD_BITS-1:0] a_q;
	logic [FIELD_BITS-1:0] b_q;
	logic [FIELD_BITS-1:0] r_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;

	logic [FIELD_BITS:0]   dbl;
	logic [FIELD_BITS-1:0] dbl_red;
	logic [FIELD_BITS:0]   sum;
	logic [FIELD_BITS-1:0] sum_red;

	// one Horner step: r = 2r mod m, then add a mod m if the bit is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? FIELD_BITS'(dbl - {1'b0, m}) : dbl[FIELD_BITS-1:0];
		sum     = {1'b0, dbl_red} + (b_q[FIELD_BITS-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= {1'b0, m}) ? FIELD_BITS'(sum - {1'b0, m}) : sum[FIELD_BITS-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CW'(FIELD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			r_q <= sum_red;
			b_q <= {b_q[FIELD_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = r_q;

endmodule

[src/ec_affine_scalar_mul_fp_unit.sv]
// Affine scalar multiplication on y^2 = x^3 + b over GF(p), double-and-add.
// Depends on ecsm_pkg and ecsm_mulmod (the one shared modular multiplier).
//
// Usage: with busy low, pulse start with the point and scalar. The item runs
// right-to-left double-and-add; every slope inverse is z^(p-2) by square and
// multiply. All products go through one bit-serial multiplier, and the
// sequencer waits for each product before it goes on. A point operation needs
// about 2*FIELD_BITS+5 products, and an item takes up to one doubling and one
// addition per scalar bit up to the top set bit. The result appears for exactly
// one cycle with result_valid high and cannot be stalled; capture it then.
// The modulus register may be written only while busy is low.
module ec_affine_scalar_mul_fp_unit #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [FIELD_BITS-1:0]  cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [FIELD_BITS-1:0]  point_x,
	input  logic [FIELD_BITS-1:0]  point_y,
	input  logic                   point_is_infinity,
	input  logic [SCALAR_BITS-1:0] scalar,
	output logic                   result_valid,
	output logic [FIELD_BITS-1:0]  result_x,
	output logic [FIELD_BITS-1:0]  result_y,
	output logic                   result_is_infinity
);

	localparam int FB = FIELD_BITS;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_RED_X    = 5'd1;
	localparam logic [4:0] S_RED_Y    = 5'd2;
	localparam logic [4:0] S_RED_D    = 5'd3;
	localparam logic [4:0] S_LOOP     = 5'd4;
	localparam logic [4:0] S_ADD_CHK  = 5'd5;
	localparam logic [4:0] S_DBL_CHK  = 5'd6;
	localparam logic [4:0] S_DBL_ST   = 5'd7;
	localparam logic [4:0] S_DBL_3    = 5'd8;
	localparam logic [4:0] S_DBL_NUM  = 5'd9;
	localparam logic [4:0] S_INV_INIT = 5'd10;
	localparam logic [4:0] S_INV_LOOP = 5'd11;
	localparam logic [4:0] S_INV_R    = 5'd12;
	localparam logic [4:0] S_INV_SQ   = 5'd13;
	localparam logic [4:0] S_INV_B    = 5'd14;
	localparam logic [4:0] S_LAM      = 5'd15;
	localparam logic [4:0] S_LAM_SQ   = 5'd16;
	localparam logic [4:0] S_X3       = 5'd17;
	localparam logic [4:0] S_Y3       = 5'd18;
	localparam logic [4:0] S_Y3F      = 5'd19;
	localparam logic [4:0] S_NEXT     = 5'd20;
	localparam logic [4:0] S_OUT      = 5'd21;
	localparam logic [4:0] S_WAIT     = 5'd22;

	logic [4:0]             state_q;
	logic [4:0]             ret_q;
	logic [FB-1:0]          mod_reg_q;
	logic [FB-1:0]          m_q;
	logic [SCALAR_BITS-1:0] k_q;
	logic [FB-1:0]          bx_q, by_q, ax_q, ay_q;
	logic                   binf_q, ainf_q;
	logic [FB-1:0]          num_q, den_q, lam_q, x3_q;
	logic [FB-1:0]          e_q, base_q, r_q;
	logic                   dbl_q, dst_acc_q;
	logic                   rv_q;

	logic                   mul_go;
	logic [FB-1:0]          mul_a, mul_b, mul_p;
	logic                   mul_done;
	logic [4:0]             mul_ret;

	logic [FB-1:0]          m_eff;
	logic [FB-1:0]          three;
	logic [FB-1:0]          px, py;

	// modular add and subtract on reduced operands
	function automatic logic [FB-1:0] madd(input logic [FB-1:0] x, input logic [FB-1:0] y,
			input logic [FB-1:0] m);
		logic [FB:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, m}) ? FB'(s - {1'b0, m}) : s[FB-1:0];
	endfunction

	function automatic logic [FB-1:0] msub(input logic [FB-1:0] x, input logic [FB-1:0] y,
			input logic [FB-1:0] m);
		return (x >= y) ? FB'(x - y) : FB'(x + (m - y));
	endfunction

	ecsm_mulmod #(
		.FIELD_BITS(FB)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.m      (m_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	// clamp the modulus to at least three
	assign m_eff = (mod_reg_q < FB'(ecsm_pkg::MODULUS_MIN)) ? FB'(ecsm_pkg::MODULUS_MIN) : mod_reg_q;
	assign three = (m_q == FB'(3)) ? '0 : FB'(3);
	assign px    = dbl_q ? bx_q : ax_q;
	assign py    = dbl_q ? by_q : ay_q;

	// multiplier operand selection per sequencer step
	always_comb begin
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_ret = S_IDLE;
		case (state_q)
			S_RED_X: begin
				mul_go = 1'b1; mul_a = FB'(1); mul_b = bx_q; mul_ret = S_RED_Y;
			end
			S_RED_Y: begin
				mul_go = 1'b1; mul_a = FB'(1); mul_b = by_q; mul_ret = S_RED_D;
			end
			S_DBL_ST: begin
				mul_go = 1'b1; mul_a = bx_q; mul_b = bx_q; mul_ret = S_DBL_3;
			end
			S_DBL_3: begin
				mul_go = 1'b1; mul_a = three; mul_b = mul_p; mul_ret = S_DBL_NUM;
			end
			S_INV_LOOP: begin
				mul_go = (e_q != '0) && e_q[0];
				mul_a = r_q; mul_b = base_q; mul_ret = S_INV_R;
			end
			S_INV_SQ: begin
				mul_go = 1'b1; mul_a = base_q; mul_b = base_q; mul_ret = S_INV_B;
			end
			S_LAM: begin
				mul_go = 1'b1; mul_a = num_q; mul_b = r_q; mul_ret = S_LAM_SQ;
			end
			S_LAM_SQ: begin
				mul_go = 1'b1; mul_a = mul_p; mul_b = mul_p; mul_ret = S_X3;
			end
			S_Y3: begin
				mul_go = 1'b1; mul_a = lam_q; mul_b = msub(px, x3_q, m_q); mul_ret = S_Y3F;
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_reg_q <= ecsm_pkg::MODULUS_RESET[FB-1:0];
		end else if (cfg_valid) begin
			mod_reg_q <= cfg_data;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			if (mul_go) begin
				ret_q   <= mul_ret;
				state_q <= S_WAIT;
			end else begin
				case (state_q)
					S_IDLE:     if (start) state_q <= S_RED_X;
					S_RED_D:    state_q <= S_LOOP;
					S_LOOP: begin
						if (k_q == '0)  state_q <= S_OUT;
						else if (k_q[0]) state_q <= S_ADD_CHK;
						else            state_q <= S_DBL_CHK;
					end
					S_ADD_CHK: begin
						if (ainf_q || binf_q) begin
							state_q <= S_DBL_CHK;
						end else if (ax_q == bx_q) begin
							state_q <= (ay_q == by_q && by_q != '0) ? S_DBL_ST : S_DBL_CHK;
						end else begin
							state_q <= S_INV_INIT;
						end
					end
					S_DBL_CHK:  state_q <= (binf_q || by_q == '0) ? S_NEXT : S_DBL_ST;
					S_DBL_NUM:  state_q <= S_INV_INIT;
					S_INV_INIT: state_q <= S_INV_LOOP;
					S_INV_LOOP: state_q <= (e_q == '0) ? S_LAM : S_INV_SQ;
					S_INV_R:    state_q <= S_INV_SQ;
					S_INV_B:    state_q <= S_INV_LOOP;
					S_X3:       state_q <= S_Y3;
					S_Y3F:      state_q <= dst_acc_q ? S_DBL_CHK : S_NEXT;
					S_NEXT:     state_q <= S_LOOP;
					S_OUT: begin
						rv_q    <= 1'b1;
						state_q <= S_IDLE;
					end
					S_WAIT:     if (mul_done) state_q <= ret_q;
					default:    state_q <= S_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					m_q    <= m_eff;
					bx_q   <= point_x;
					by_q   <= point_y;
					binf_q <= point_is_infinity;
					k_q    <= scalar;
					ax_q   <= '0;
					ay_q   <= '0;
					ainf_q <= 1'b1;
				end
			end
			S_RED_Y: bx_q <= mul_p;
			S_RED_D: begin
				if (binf_q) begin
					bx_q <= '0;
					by_q <= '0;
				end else begin
					by_q <= mul_p;
				end
			end
			S_ADD_CHK: begin
				dst_acc_q <= 1'b1;
				if (ainf_q) begin
					ax_q   <= bx_q;
					ay_q   <= by_q;
					ainf_q <= binf_q;
				end else if (binf_q) begin
					ainf_q <= ainf_q;
				end else if (ax_q == bx_q) begin
					dbl_q <= 1'b1;
					if (ay_q != by_q || by_q == '0) begin
						ax_q   <= '0;
						ay_q   <= '0;
						ainf_q <= 1'b1;
					end
				end else begin
					dbl_q <= 1'b0;
					num_q <= msub(by_q, ay_q, m_q);
					den_q <= msub(bx_q, ax_q, m_q);
				end
			end
			S_DBL_CHK: begin
				dst_acc_q <= 1'b0;
				dbl_q     <= 1'b1;
				if (binf_q || by_q == '0) begin
					bx_q   <= '0;
					by_q   <= '0;
					binf_q <= 1'b1;
				end
			end
			S_DBL_NUM: begin
				num_q <= mul_p;
				den_q <= madd(by_q, by_q, m_q);
			end
			S_INV_INIT: begin
				r_q    <= FB'(1);
				base_q <= den_q;
				e_q    <= m_q - FB'(2);
			end
			S_INV_R: r_q <= mul_p;
			S_INV_B: begin
				base_q <= mul_p;
				e_q    <= e_q >> 1;
			end
			S_LAM_SQ: lam_q <= mul_p;
			S_X3: begin
				if (dbl_q) x3_q <= msub(mul_p, madd(bx_q, bx_q, m_q), m_q);
				else       x3_q <= msub(msub(mul_p, ax_q, m_q), bx_q, m_q);
			end
			S_Y3F: begin
				if (dst_acc_q) begin
					ax_q   <= x3_q;
					ay_q   <= msub(mul_p, py, m_q);
					ainf_q <= 1'b0;
				end else begin
					bx_q   <= x3_q;
					by_q   <= msub(mul_p, py, m_q);
					binf_q <= 1'b0;
				end
			end
			S_NEXT: k_q <= k_q >> 1;
			S_OUT: begin
				result_x           <= ax_q;
				result_y           <= ay_q;
				result_is_infinity <= ainf_q;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q != S_IDLE);
	assign result_valid = rv_q;

endmodule
